[design/nfba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_pkg: shared definitions for the next-fit block allocator
// Field widths, operation codes and parameter defaults used across the block.
// ----------------------------------------------------------------------------
package nfba_pkg;

	// parameter defaults
	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_WIDTH_DEF = 16;

	// fixed field widths
	localparam int FUNC_W   = 1;
	localparam int INDEX_W  = 4;
	localparam int AMOUNT_W = 16;
	localparam int COUNT_W  = 5;

	// block count after reset
	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

endpackage

`default_nettype wire

[design/nfba_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_if: request and response channels of the allocator
// Valid/ready channels; a beat moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface nfba_in_if;
	logic                          valid;
	logic                          ready;
	logic [nfba_pkg::FUNC_W-1:0]   func;
	logic [nfba_pkg::INDEX_W-1:0]  block_index;
	logic [nfba_pkg::AMOUNT_W-1:0] amount;

	modport source (output valid, func, block_index, amount, input ready);
	modport sink   (input valid, func, block_index, amount, output ready);
endinterface

interface nfba_out_if;
	logic                          valid;
	logic                          ready;
	logic                          granted;
	logic [nfba_pkg::INDEX_W-1:0]  block_number;
	logic [nfba_pkg::AMOUNT_W-1:0] remaining;

	modport source (output valid, granted, block_number, remaining, input ready);
	modport sink   (input valid, granted, block_number, remaining, output ready);
endinterface

`default_nettype wire

[design/nfba_cap_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_cap_mem: block capacity table
// One write and one registered read per cycle; per-entry valid bits make an
// entry that was never written read as zero right after reset.
// ----------------------------------------------------------------------------
module nfba_cap_mem #(
	parameter int DEPTH = nfba_pkg::MAX_BLOCKS_DEF,
	parameter int AW    = 4,
	parameter int DW    = nfba_pkg::SIZE_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [DW-1:0] rdata_q;
	logic          rvalid_q;

	// mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// store capacity
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// register read data with its valid bit
	always_ff @(posedge clk) begin
		rdata_q  <= mem[raddr];
		rvalid_q <= valid_q[raddr];
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

[design/nfba_fit_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_fit_unit: shared compare and subtract
// One subtractor gives both the fit test (no borrow) and the capacity left.
// ----------------------------------------------------------------------------
module nfba_fit_unit #(
	parameter int SIZE_WIDTH = nfba_pkg::SIZE_WIDTH_DEF
) (
	input  wire logic [SIZE_WIDTH-1:0]            cap,
	input  wire logic [nfba_pkg::AMOUNT_W-1:0]    req,
	output logic                                  fit,
	output logic      [SIZE_WIDTH-1:0]            diff
);

	localparam int CW = ((SIZE_WIDTH > nfba_pkg::AMOUNT_W) ? SIZE_WIDTH
		: nfba_pkg::AMOUNT_W) + 1;

	logic [CW-1:0] d;

	// borrow out means the request does not fit
	assign d    = CW'(cap) - CW'(req);
	assign fit  = ~d[CW-1];
	assign diff = SIZE_WIDTH'(d);

endmodule

`default_nettype wire

[design/next_fit_block_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_block_allocator: next-fit search over a block capacity table
// Loads set one block's capacity; allocates scan circularly from a roving
// pointer and take the request from the first block that holds it.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    func, block_index, amount
//  out_ch    out  valid/ready    granted, block_number, remaining
//  cfg       in   cfg_we         cfg_wdata (block_count)
//
//  An allocate does one table read and one compare/subtract per block
//  visited, set by the single read port of the capacity table and the
//  shared fit unit.
//  Reset clears the table valid bits, the pointer and the output valid;
//  block_count returns to 16. The result waits in the output register while
//  out_ch stalls; new beats are taken whenever the sequencer is idle.
// ----------------------------------------------------------------------------
module next_fit_block_allocator #(
	parameter int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_WIDTH = nfba_pkg::SIZE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [nfba_pkg::COUNT_W-1:0]   cfg_wdata,
	nfba_in_if.sink                             in_ch,
	nfba_out_if.source                          out_ch
);

	localparam int CW = nfba_pkg::COUNT_W;
	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int PW = ((IW > CW) ? IW : CW) + 1;
	localparam int CLAMP = (MAX_BLOCKS > 31) ? 31 : MAX_BLOCKS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] block_count_q;
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] pos_q;
	logic [CW-1:0] k_q;
	logic [nfba_pkg::AMOUNT_W-1:0] amt_q;
	logic          res_granted_q;
	logic [IW-1:0] res_pos_q;
	logic [SIZE_WIDTH-1:0] res_rem_q;
	logic          out_v_q;
	logic          out_granted_q;
	logic [nfba_pkg::INDEX_W-1:0]  out_block_q;
	logic [nfba_pkg::AMOUNT_W-1:0] out_rem_q;

	logic [CW-1:0] cnt_eff;
	logic [IW-1:0] start_pos;
	logic [IW-1:0] nxt_pos;
	logic          in_fire;
	logic          ld_fire;
	logic          al_fire;
	logic          scan_hit;
	logic          scan_last;
	logic          out_free;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [SIZE_WIDTH-1:0] mem_wdata;
	logic [IW-1:0] mem_raddr;
	logic [SIZE_WIDTH-1:0] mem_rdata;
	logic          fit;
	logic [SIZE_WIDTH-1:0] fit_diff;

	// clamp the block count to the table size
	assign cnt_eff = (32'(block_count_q) > MAX_BLOCKS) ? CW'(CLAMP) : block_count_q;

	// search start and circular successor of the current position
	assign start_pos = (PW'(ptr_q) >= PW'(cnt_eff)) ? '0 : ptr_q;
	assign nxt_pos   = ((PW'(pos_q) + PW'(1)) < PW'(cnt_eff)) ? pos_q + IW'(1) : '0;

	// handshake decode
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign ld_fire     = in_fire && (in_ch.func == nfba_pkg::FUNC_LOAD)
		&& (32'(in_ch.block_index) < MAX_BLOCKS);
	assign al_fire     = in_fire && (in_ch.func == nfba_pkg::FUNC_ALLOC);
	assign scan_hit    = (state_q == ST_SCAN) && fit;
	assign scan_last   = (k_q == cnt_eff - CW'(1));
	assign out_free    = !out_v_q || out_ch.ready;

	// table ports: loads in idle, hit write-back during the scan
	assign mem_raddr = (state_q == ST_IDLE) ? start_pos : nxt_pos;
	assign mem_we    = ld_fire || scan_hit;
	assign mem_waddr = ld_fire ? IW'(in_ch.block_index) : pos_q;
	assign mem_wdata = ld_fire ? SIZE_WIDTH'(in_ch.amount) : fit_diff;

	nfba_cap_mem #(
		.DEPTH (MAX_BLOCKS),
		.AW    (IW),
		.DW    (SIZE_WIDTH)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	nfba_fit_unit #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_fit (
		.cap (mem_rdata),
		.req (amt_q),
		.fit (fit),
		.diff(fit_diff)
	);

	// sequencer, pointer, config and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			block_count_q <= nfba_pkg::COUNT_RESET;
			ptr_q         <= '0;
			out_v_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				block_count_q <= cfg_wdata;
			end
			// raise the result beat from the result state, drop it once taken
			if (state_q == ST_OUT && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (al_fire) begin
						state_q <= (cnt_eff == '0) ? ST_OUT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (fit) begin
						ptr_q   <= nxt_pos;
						state_q <= ST_OUT;
					end else if (scan_last) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan position, request and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && al_fire) begin
			pos_q         <= start_pos;
			k_q           <= '0;
			amt_q         <= in_ch.amount;
			res_granted_q <= 1'b0;
			res_pos_q     <= '0;
			res_rem_q     <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (fit) begin
				res_granted_q <= 1'b1;
				res_pos_q     <= pos_q;
				res_rem_q     <= fit_diff;
			end else begin
				pos_q <= nxt_pos;
				k_q   <= k_q + CW'(1);
			end
		end
		if (state_q == ST_OUT && out_free) begin
			out_granted_q <= res_granted_q;
			out_block_q   <= nfba_pkg::INDEX_W'(res_pos_q);
			out_rem_q     <= nfba_pkg::AMOUNT_W'(res_rem_q);
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.granted      = out_granted_q;
	assign out_ch.block_number = out_block_q;
	assign out_ch.remaining    = out_rem_q;

	// scan never visits more blocks than are in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (k_q < cnt_eff))
		else $error("scan ran past the block count");

	// an allocate with a block count of zero goes straight to the result
	a_empty_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(al_fire && cnt_eff == '0) |=> (state_q == ST_OUT))
		else $error("allocate with no blocks did not miss at once");

	// pointer moves only on a hit
	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!scan_hit |=> $stable(ptr_q))
		else $error("pointer moved without a hit");

	// a result beat appears only out of the result state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside the result state");

endmodule

`default_nettype wire
